### design/bpcq_pkg.sv
// Package for the button press classifier queue: sizes, codes and transfer types.
package bpcq_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int BTN_W       = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam int TICK_W  = 10;
    localparam int LIMIT_W = 16;
    localparam int COUNT_W = 4;

    localparam logic [TICK_W-1:0]  TICK_PERIOD_RST = TICK_W'(10);
    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = LIMIT_W'(50);
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = LIMIT_W'(500);
    localparam logic [COUNT_W-1:0] BURST_START_RST = COUNT_W'(3);

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_BURST = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_TICK_PERIOD = 2'd0,
        REG_SHORT_LIMIT = 2'd1,
        REG_LONG_LIMIT  = 2'd2,
        REG_BURST_START = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             cmd;
        logic [BTN_W-1:0] button_index;
        logic             pressed;
    } t_in_item;

    typedef struct packed {
        logic             event_valid;
        logic [1:0]       event_kind;
        logic [BTN_W-1:0] event_button;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BTN_W-1:0] button;
    } t_event;

endpackage

### design/button_press_classifier_queue.sv
// Button press classifier with event queue: top level.
//
// Usage. The input channel (i_in_valid, o_in_stall, i_in_data) carries commands. A sample
// command gives one button's level for one tick; the block advances that button's hold
// timer, and on a long limit or a release it queues short, long, burst and end events.
// A read command takes the oldest event from an eight-slot queue (one slot stays unused)
// and produces one result on the output channel (o_out_valid, i_out_stall, o_out_data);
// an empty queue gives a result with event_valid low. Samples produce no result.
// Registers (tick period, short limit, long limit, burst start) sit on an APB-style port
// at byte addresses 0, 4, 8 and 12; write them only while the block is idle.
// Throughput: one command per cycle while o_in_stall is low. Each sample touches one
// button entry and at most two queue slots, each read one slot, all settled in
// combinational logic ahead of the state registers. Read results are registered.
// Stall: while the receiver stalls, the held result stays put and one more result may
// be parked in a skid register; o_in_stall rises only when that skid register is full.
// Reset: clears all hold timers and long counts, empties the queue and both output
// registers, and restores register defaults. Queue slot contents are not cleared.
module button_press_classifier_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bpcq_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bpcq_pkg::t_out_item           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpcq_pkg::ADDR_W-1:0]   paddr,
    input  logic [bpcq_pkg::DATA_W-1:0]   pwdata,
    output logic [bpcq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int BW = bpcq_pkg::BTN_W;
    localparam int PW = bpcq_pkg::PTR_W;
    localparam int LW = bpcq_pkg::LIMIT_W;
    localparam int CW = bpcq_pkg::COUNT_W;
    localparam int TW = bpcq_pkg::TICK_W;
    localparam logic [PW-1:0] LAST_SLOT = PW'(bpcq_pkg::QUEUE_DEPTH - 1);

    // Configuration registers
    logic [TW-1:0] r_tick_period;
    logic [LW-1:0] r_short_limit;
    logic [LW-1:0] r_long_limit;
    logic [CW-1:0] r_burst_start;

    // Per-button state
    logic [LW-1:0] r_hold [bpcq_pkg::NUM_BUTTONS];
    logic [CW-1:0] r_lcnt [bpcq_pkg::NUM_BUTTONS];

    // Event queue
    bpcq_pkg::t_event r_store [bpcq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_head;
    logic [PW-1:0]    r_tail;

    // Output register and skid register
    logic                r_out_valid;
    bpcq_pkg::t_out_item r_out_data;
    logic                r_skid_valid;
    bpcq_pkg::t_out_item r_skid_data;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= bpcq_pkg::TICK_PERIOD_RST;
            r_short_limit <= bpcq_pkg::SHORT_LIMIT_RST;
            r_long_limit  <= bpcq_pkg::LONG_LIMIT_RST;
            r_burst_start <= bpcq_pkg::BURST_START_RST;
        end else if (cfg_wr) begin
            unique case (bpcq_pkg::t_reg_idx'(paddr[3:2]))
                bpcq_pkg::REG_TICK_PERIOD: r_tick_period <= pwdata[TW-1:0];
                bpcq_pkg::REG_SHORT_LIMIT: r_short_limit <= pwdata[LW-1:0];
                bpcq_pkg::REG_LONG_LIMIT:  r_long_limit  <= pwdata[LW-1:0];
                bpcq_pkg::REG_BURST_START: r_burst_start <= pwdata[CW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (bpcq_pkg::t_reg_idx'(paddr[3:2]))
            bpcq_pkg::REG_TICK_PERIOD: prdata = {{(bpcq_pkg::DATA_W-TW){1'b0}}, r_tick_period};
            bpcq_pkg::REG_SHORT_LIMIT: prdata = {{(bpcq_pkg::DATA_W-LW){1'b0}}, r_short_limit};
            bpcq_pkg::REG_LONG_LIMIT:  prdata = {{(bpcq_pkg::DATA_W-LW){1'b0}}, r_long_limit};
            bpcq_pkg::REG_BURST_START: prdata = {{(bpcq_pkg::DATA_W-CW){1'b0}}, r_burst_start};
        endcase
    end

    // ---------------- input transfer ----------------
    logic          in_xfer;
    logic          is_read;
    logic          is_sample;
    logic [BW-1:0] btn;

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign btn        = i_in_data.button_index;
    assign is_read    = in_xfer && (i_in_data.cmd == bpcq_pkg::CMD_READ);
    assign is_sample  = in_xfer && (i_in_data.cmd == bpcq_pkg::CMD_SAMPLE)
                        && ({1'b0, btn} < (BW+1)'(bpcq_pkg::NUM_BUTTONS));

    // ---------------- per-button classification ----------------
    logic [LW-1:0] cur_hold;
    logic [CW-1:0] cur_lcnt;
    logic [LW:0]   hold_sum;
    logic [LW-1:0] hold_sat;
    logic          reach_short;
    logic [LW-1:0] n_hold;
    logic [CW-1:0] n_lcnt;
    logic          ev_a_valid;
    logic [1:0]    ev_a_kind;
    logic          ev_b_valid;

    assign cur_hold    = r_hold[btn];
    assign cur_lcnt    = r_lcnt[btn];
    assign hold_sum    = {1'b0, cur_hold} + {{(LW+1-TW){1'b0}}, r_tick_period};
    // Saturate the timer at its full scale
    assign hold_sat    = hold_sum[LW] ? '1 : hold_sum[LW-1:0];
    assign reach_short = cur_hold >= r_short_limit;

    always_comb begin
        n_hold     = cur_hold;
        n_lcnt     = cur_lcnt;
        ev_a_valid = 1'b0;
        ev_a_kind  = bpcq_pkg::KIND_SHORT;
        ev_b_valid = 1'b0;
        if (i_in_data.pressed) begin
            n_hold = hold_sat;
            if (hold_sat >= r_long_limit) begin
                // Long limit reached: fire long or burst, restart the timer
                ev_a_valid = 1'b1;
                n_hold     = '0;
                if (cur_lcnt >= r_burst_start) begin
                    ev_a_kind = bpcq_pkg::KIND_BURST;
                end else begin
                    ev_a_kind = bpcq_pkg::KIND_LONG;
                    n_lcnt    = cur_lcnt + CW'(1);
                end
            end
        end else begin
            // Release without a long press: short then end once the short limit is met.
            // After a long press: end on the short limit, and again on a cleared timer.
            ev_a_valid = reach_short;
            ev_a_kind  = (cur_lcnt == '0) ? bpcq_pkg::KIND_SHORT : bpcq_pkg::KIND_END;
            ev_b_valid = (cur_lcnt == '0) ? reach_short : (cur_hold == '0);
            n_hold     = '0;
            n_lcnt     = '0;
        end
    end

    // ---------------- enqueue, up to two events ----------------
    logic             wr_a;
    logic             wr_b;
    logic [PW-1:0]    addr_b;
    logic [PW-1:0]    n_head;
    bpcq_pkg::t_event ev_a;
    bpcq_pkg::t_event ev_b;

    assign ev_a = '{kind: ev_a_kind, button: btn};
    assign ev_b = '{kind: bpcq_pkg::KIND_END, button: btn};

    always_comb begin
        wr_a   = is_sample && ev_a_valid && (next_slot(r_head) != r_tail);
        addr_b = wr_a ? next_slot(r_head) : r_head;
        wr_b   = is_sample && ev_b_valid && (next_slot(addr_b) != r_tail);
        n_head = wr_b ? next_slot(addr_b) : addr_b;
    end

    // ---------------- dequeue ----------------
    logic                q_empty;
    bpcq_pkg::t_out_item rd_item;

    assign q_empty = (r_head == r_tail);

    always_comb begin
        rd_item = '0;
        if (!q_empty) begin
            rd_item.event_valid  = 1'b1;
            rd_item.event_kind   = r_store[r_tail].kind;
            rd_item.event_button = r_store[r_tail].button;
        end
    end

    // ---------------- state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bpcq_pkg::NUM_BUTTONS; i++) begin
                r_hold[i] <= '0;
                r_lcnt[i] <= '0;
            end
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (is_sample) begin
                r_hold[btn] <= n_hold;
                r_lcnt[btn] <= n_lcnt;
                r_head      <= n_head;
            end
            if (is_read && !q_empty) begin
                r_tail <= next_slot(r_tail);
            end
        end
    end

    // Slot contents need no reset: only written slots are ever read
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_store[r_head] <= ev_a;
        end
        if (wr_b) begin
            r_store[addr_b] <= ev_b;
        end
    end

    // ---------------- output register and skid ----------------
    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // Drain the skid register once the held result is taken
                if (out_free) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (is_read) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_data <= r_skid_data;
            end
        end else if (is_read) begin
            if (out_free) begin
                r_out_data <= rd_item;
            end else begin
                r_skid_data <= rd_item;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### design/bpcq_checker.sv
// Port-level checker for the button press classifier queue, with its bind.
module bpcq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input bpcq_pkg::t_out_item           o_out_data,
    input logic                          psel,
    input logic                          penable,
    input logic                          pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Input stall only follows an output stall
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall without output stall");

    // A parked result implies a held result
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stall with empty output");

    // Empty-queue results carry zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.event_valid |->
            o_out_data.event_kind == 2'd0 && o_out_data.event_button == '0)
        else $error("empty read with non-zero fields");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("pready low during access");

endmodule

bind button_press_classifier_queue bpcq_checker u_bpcq_checker (.*);
